// ===== rtl/srgb_contrast_ratio_top_assert.svh =====
// Assertion macros for the sRGB contrast ratio block.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef SRGB_CONTRAST_RATIO_TOP_ASSERT_SVH
`define SRGB_CONTRAST_RATIO_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("contrast ratio block: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("contrast ratio block: next-cycle check failed");

`endif

// ===== rtl/scr_pkg.sv =====
// Shared constants, types and the sRGB curve function of the contrast ratio block.
// No dependencies.
package scr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COLOUR_W      = 24;
  localparam int THRESH_W      = 21;
  localparam int THRESH_FRAC   = 16;
  localparam int THRESH_RESET  = 196608;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 24;

  typedef logic [COLOUR_W-1:0] colour_t;

  localparam logic [CFG_IDX_W-1:0] REG_GROUND_COLOUR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INK_THRESHOLD = 1'b1;

  localparam colour_t COLOUR_WHITE = 24'hFFFFFF;

  // Luminance weights scaled by ten thousand, with rounding bias.
  localparam int LUM_W_R  = 2126;
  localparam int LUM_W_G  = 7152;
  localparam int LUM_W_B  = 722;
  localparam int LUM_BIAS = 5000;
  localparam int LUM_DIV  = 10000;

  // The 0.05 floor is held exactly as a factor of twenty on the luminance.
  localparam int FLOOR_MUL   = 20;
  localparam int WHITE_RATIO = 21;
  localparam int CURVE_KNEE  = 10;

  function automatic longint unsigned fifth_q31(longint unsigned s);
    longint unsigned p2;
    longint unsigned p4;
    p2 = (s * s) >> 31;
    p4 = (p2 * p2) >> 31;
    return (p4 * s) >> 31;
  endfunction

  // Linear value of one 8-bit sRGB code in Q1.fb. Only evaluated at elaboration.
  function automatic longint unsigned curve_value(int unsigned c, int unsigned fb);
    longint unsigned cc;
    longint unsigned t;
    longint unsigned sq;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    cc = longint'(c);
    if (c <= CURVE_KNEE) begin
      return (cc * 64'd50 * (64'd1 << fb) + 64'd82365) / 64'd164730;
    end
    t  = (((64'd1000 * cc + 64'd14025) << 31) + 64'd134512) / 64'd269025;
    sq = (t * t) >> 31;
    lo = 64'd0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      if (fifth_q31(mid) <= sq) begin
        lo = mid;
      end else begin
        hi = mid - 64'd1;
      end
    end
    return (sq * lo + (64'd1 << (61 - fb))) >> (62 - fb);
  endfunction

endpackage

// ===== rtl/scr_lum.sv =====
// Four-stage relative luminance pipeline for one RGB colour.
// Depends on scr_pkg for the curve function and the channel weights.
module scr_lum import scr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  colour_t              colour,
  output logic [FRAC_BITS:0]   y
);

  localparam int LW   = FRAC_BITS + 1;
  localparam int SW   = FRAC_BITS + 14;
  localparam int RS   = SW + 13;
  localparam logic [SW-1:0] RECIP = SW'((64'd1 << RS) / LUM_DIV);

  logic [LW-1:0] curve_tbl [256];

  for (genvar k = 0; k < 256; k++) begin : g_curve
    localparam logic [LW-1:0] CV = LW'(curve_value(k, FRAC_BITS));
    assign curve_tbl[k] = CV;
  end

  logic [LW-1:0]   r_r, g_r, b_r;
  logic [SW-1:0]   sum_r, x_r, rem;
  logic [LW-1:0]   qe_r, y_r;
  logic [2*SW-1:0] prod;

  assign prod = (2*SW)'(sum_r) * (2*SW)'(RECIP);
  // The reciprocal estimate is at most one low; one compare fixes it.
  assign rem  = x_r - SW'(qe_r) * SW'(LUM_DIV);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= curve_tbl[colour[23:16]];
      g_r   <= curve_tbl[colour[15:8]];
      b_r   <= curve_tbl[colour[7:0]];
      sum_r <= SW'(r_r) * SW'(LUM_W_R) + SW'(g_r) * SW'(LUM_W_G)
             + SW'(b_r) * SW'(LUM_W_B) + SW'(LUM_BIAS);
      x_r   <= sum_r;
      qe_r  <= prod[RS +: LW];
      y_r   <= qe_r + LW'(rem >= SW'(LUM_DIV));
    end
  end

  assign y = y_r;

endmodule

// ===== rtl/scr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Depends on scr_pkg for the default fraction width.
module scr_div import scr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [2*FRAC_BITS+4:0]   num,
  input  logic [FRAC_BITS+4:0]     den,
  input  logic [SIDE_W-1:0]        side_in,
  output logic [FRAC_BITS+4:0]     quo,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int NW = 2 * FRAC_BITS + 5;
  localparam int DW = FRAC_BITS + 5;
  localparam int QW = FRAC_BITS + 5;
  localparam int EW = DW + QW;

  logic [NW-1:0]     rem_r  [QW];
  logic [DW-1:0]     den_r  [QW];
  logic [QW-1:0]     q_r    [QW];
  logic [SIDE_W-1:0] side_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int J = QW - 1 - s;
    logic [NW-1:0]     rem_in, rem_nxt;
    logic [DW-1:0]     den_in;
    logic [QW-1:0]     q_in, q_nxt;
    logic [SIDE_W-1:0] side_in_s;
    logic [EW-1:0]     shifted;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in    = num;
      assign den_in    = den;
      assign q_in      = '0;
      assign side_in_s = side_in;
    end else begin : g_next
      assign rem_in    = rem_r[s-1];
      assign den_in    = den_r[s-1];
      assign q_in      = q_r[s-1];
      assign side_in_s = side_r[s-1];
    end

    always_comb begin
      shifted  = EW'(den_in) << J;
      ge       = EW'(rem_in) >= shifted;
      rem_nxt  = ge ? NW'(EW'(rem_in) - shifted) : rem_in;
      q_nxt    = q_in;
      q_nxt[J] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        den_r[s]  <= den_in;
        q_r[s]    <= q_nxt;
        side_r[s] <= side_in_s;
      end
    end
  end

  assign quo      = q_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

// ===== rtl/srgb_contrast_ratio_top.sv =====
// Top level of the sRGB relative luminance and contrast ratio block.
// Depends on scr_pkg, scr_lum, scr_div and srgb_contrast_ratio_top_assert.svh.
//
//   Channel  Direction  Handshake              Carries
//   in_      input      in_valid / in_ready    two 0xRRGGBB colours per item
//   out_     output     out_valid / out_ready  two luminances, ratio, ink colour
//   cfg_     input      cfg_we                 ground colour, ink threshold
//
// One item enters per cycle while in_ready is high. The path runs through four
// luminance stages, one operand stage, one divider stage per quotient bit, and the
// output register. The divider's bit-per-stage chain sets the depth. Reset (rst_n
// low at a clock edge) empties the pipeline and loads the register defaults. A
// stalled output holds the whole pipeline only when its last stage is full; bubbles
// still move up behind a waiting result.
`include "srgb_contrast_ratio_top_assert.svh"

module srgb_contrast_ratio_top import scr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  colour_t               in_first_colour,
  input  colour_t               in_second_colour,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC_BITS:0]    out_first_luminance,
  output logic [FRAC_BITS:0]    out_second_luminance,
  output logic [FRAC_BITS+4:0]  out_contrast_ratio,
  output colour_t               out_ink_colour,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LW     = FRAC_BITS + 1;
  localparam int NW     = 2 * FRAC_BITS + 5;
  localparam int DW     = FRAC_BITS + 5;
  localparam int QW     = FRAC_BITS + 5;
  localparam int KW     = FRAC_BITS + 6;
  localparam int KDW    = KW + DW;
  localparam int KWW    = THRESH_W + FRAC_BITS + 1;
  localparam int SIDE_W = 2 * LW + 1;
  // Luminance stages, the operand stage and the divider stages.
  localparam int NS     = 5 + QW;

  localparam logic [LW-1:0]  ONE_L   = LW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]  ONE_Q   = QW'(1) << FRAC_BITS;
  localparam logic [KDW-1:0] N_WHITE = KDW'(WHITE_RATIO) << (2 * FRAC_BITS);
  localparam logic [KW-1:0]  K_RST   =
    KW'(((64'(THRESH_RESET) << FRAC_BITS) + ((64'd1 << THRESH_FRAC) - 64'd1))
        >> THRESH_FRAC);

  // Configuration. The threshold is kept as the smallest quotient that reaches it,
  // so the white-ink test becomes one multiply and compare against the dividend.
  colour_t         ground_r;
  logic [KW-1:0]   k_r, k_nxt;
  logic [KWW-1:0]  k_wide;

  always_comb begin
    k_wide = (KWW'(cfg_data[THRESH_W-1:0]) << FRAC_BITS)
           + KWW'((64'd1 << THRESH_FRAC) - 64'd1);
    k_nxt  = KW'(k_wide >> THRESH_FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ground_r <= '0;
      k_r      <= K_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUND_COLOUR: ground_r <= cfg_data[COLOUR_W-1:0];
        REG_INK_THRESHOLD: k_r      <= k_nxt;
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves together unless the last stage holds a
  // result that the output register cannot take.
  logic [NS-1:0] v_r;
  logic          pipe_en;
  logic          out_valid_r;

  assign pipe_en  = !v_r[NS-1] || !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (pipe_en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // Luminance of both colours.
  logic [LW-1:0] y1, y2;

  scr_lum #(.FRAC_BITS(FRAC_BITS)) u_lum_first (
    .clk(clk), .en(pipe_en), .colour(in_first_colour), .y(y1)
  );

  scr_lum #(.FRAC_BITS(FRAC_BITS)) u_lum_second (
    .clk(clk), .en(pipe_en), .colour(in_second_colour), .y(y2)
  );

  // Operand stage: order the luminances, form dividend and divisor, and the
  // product used by the white-ink test. White is never darker than the second
  // colour, so its divisor is built from the second luminance.
  logic [LW-1:0]  hi, lo;
  logic [LW-1:0]  y1_p_r, y2_p_r;
  logic [NW-1:0]  num_r;
  logic [DW-1:0]  den_r;
  logic [DW-1:0]  den_white;
  logic [KDW-1:0] kd_r;

  always_comb begin
    hi        = (y1 > y2) ? y1 : y2;
    lo        = (y1 > y2) ? y2 : y1;
    den_white = DW'(y2) * DW'(FLOOR_MUL) + (DW'(1) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      y1_p_r <= y1;
      y2_p_r <= y2;
      num_r  <= (NW'(hi) * NW'(FLOOR_MUL) + (NW'(1) << FRAC_BITS)) << FRAC_BITS;
      den_r  <= DW'(lo) * DW'(FLOOR_MUL) + (DW'(1) << FRAC_BITS);
      kd_r   <= KDW'(k_r) * KDW'(den_white);
    end
  end

  logic              ink_white;
  logic [SIDE_W-1:0] side_in, side_out;
  logic [QW-1:0]     quo;

  assign ink_white = N_WHITE >= kd_r;
  assign side_in   = {y1_p_r, y2_p_r, ink_white};

  scr_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
    .clk(clk), .en(pipe_en), .num(num_r), .den(den_r),
    .side_in(side_in), .quo(quo), .side_out(side_out)
  );

  // Output register.
  logic          out_load;
  logic [LW-1:0] y1_out_r, y2_out_r;
  logic [QW-1:0] ratio_out_r;
  colour_t       ink_out_r;

  assign out_load = v_r[NS-1] && pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      y1_out_r    <= side_out[SIDE_W-1 -: LW];
      y2_out_r    <= side_out[LW:1];
      ratio_out_r <= quo;
      ink_out_r   <= side_out[0] ? COLOUR_WHITE : ground_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_first_luminance  = y1_out_r;
  assign out_second_luminance = y2_out_r;
  assign out_contrast_ratio   = ratio_out_r;
  assign out_ink_colour       = ink_out_r;

  // A ratio below one means the luminances were swapped or the divider slipped.
  `SCR_ASSERT_NOW(a_ratio_floor, out_valid, out_contrast_ratio >= ONE_Q)
  `SCR_ASSERT_NOW(a_lum_range, out_valid,
                  (out_first_luminance <= ONE_L) && (out_second_luminance <= ONE_L))
  `SCR_ASSERT_NOW(a_ink_choice, out_valid,
                  (out_ink_colour == COLOUR_WHITE) || (out_ink_colour == ground_r))
  `SCR_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_r[0])

endmodule

// ===== bench/tb_srgb_contrast_ratio_top.sv =====
// Self-checking testbench for the sRGB luminance and contrast ratio block.
// Depends on scr_pkg and the RTL of srgb_contrast_ratio_top; reads no files.
module tb_srgb_contrast_ratio_top import scr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LUM_W = FB + 1;
  localparam int RATIO_W = FB + 5;
  // Pipeline depth is FRAC_BITS + 11; the settle time leaves margin on top.
  localparam int SETTLE_CYCLES = FB + 11 + 16;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [LUM_W-1:0]   lum_a;
    logic [LUM_W-1:0]   lum_b;
    logic [RATIO_W-1:0] ratio;
    colour_t            ink;
  } shade_t;

  typedef struct {
    colour_t first;
    colour_t second;
    bit      typed;
    shade_t  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  colour_t               in_first_colour;
  colour_t               in_second_colour;
  logic                  out_valid;
  logic                  out_ready;
  logic [LUM_W-1:0]      out_first_luminance;
  logic [LUM_W-1:0]      out_second_luminance;
  logic [RATIO_W-1:0]    out_contrast_ratio;
  colour_t               out_ink_colour;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  srgb_contrast_ratio_top uut (.*);

  // Mirror of the configuration registers and the linearisation table.
  colour_t             ground_mirror;
  logic [THRESH_W-1:0] thresh_mirror;
  longint unsigned     lin_table [256];

  shade_t  pending_shades[$];
  int      mismatches;
  longint  cycles;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint unsigned pow5_q31(longint unsigned s);
    longint unsigned sq;
    longint unsigned qd;
    sq = (s * s) >> 31;
    qd = (sq * sq) >> 31;
    return (qd * s) >> 31;
  endfunction

  // Linear light of one 8-bit code: straight segment up to the knee, then the
  // 2.4 power taken as t*t multiplied by the fifth root of t*t.
  function automatic longint unsigned linearise(int code);
    longint unsigned t;
    longint unsigned tt;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    if (code <= 10)
      return (longint'(code) * 50 * (64'd1 << FB) + 82365) / 164730;
    t  = (((64'd1000 * code + 14025) << 31) + 134512) / 269025;
    tt = (t * t) >> 31;
    lo = 0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (pow5_q31(mid) <= tt) lo = mid;
      else hi = mid - 1;
    end
    return (tt * lo + (64'd1 << (61 - FB))) >> (62 - FB);
  endfunction

  function automatic longint unsigned rel_luminance(colour_t c);
    return (2126 * lin_table[c[23:16]] + 7152 * lin_table[c[15:8]]
            + 722 * lin_table[c[7:0]] + 5000) / 10000;
  endfunction

  function automatic longint unsigned contrast_q(longint unsigned ya, longint unsigned yb);
    longint unsigned top;
    longint unsigned bot;
    top = (ya > yb) ? ya : yb;
    bot = (ya > yb) ? yb : ya;
    return ((20 * top + (64'd1 << FB)) << FB) / (20 * bot + (64'd1 << FB));
  endfunction

  function automatic shade_t predict_shade(colour_t a, colour_t b);
    shade_t s;
    longint unsigned ya;
    longint unsigned yb;
    longint unsigned vs_white;
    ya = rel_luminance(a);
    yb = rel_luminance(b);
    vs_white = contrast_q(64'd1 << FB, yb);
    s.lum_a = ya[LUM_W-1:0];
    s.lum_b = yb[LUM_W-1:0];
    s.ratio = contrast_q(ya, yb);
    // Threshold is Q5.16, the ratio Q5.FB: align both before comparing.
    s.ink = ((vs_white << 16) >= (longint'(thresh_mirror) << FB)) ? COLOUR_WHITE
                                                                 : ground_mirror;
    return s;
  endfunction

  // Result checker: every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin
    shade_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_shades.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item, nothing pending");
      end else begin
        w = pending_shades.pop_front();
        if (out_first_luminance !== w.lum_a || out_second_luminance !== w.lum_b ||
            out_contrast_ratio !== w.ratio || out_ink_colour !== w.ink) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp lum %0d/%0d ratio %0d ink %h, got %0d/%0d %0d %h",
                     w.lum_a, w.lum_b, w.ratio, w.ink, out_first_luminance,
                     out_second_luminance, out_contrast_ratio, out_ink_colour);
        end
      end
    end
  end

  // Receiver stalls follow a randomly redrawn pattern: always ready, coin toss,
  // mostly stalled, or a fixed on-off rhythm taken from a counter bit.
  int stall_mode;
  int stall_cnt;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_cnt[2];
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one item, holds it until accepted, then records its prediction.
  task automatic send_item(colour_t a, colour_t b, bit typed, shade_t want);
    in_valid         <= 1'b1;
    in_first_colour  <= a;
    in_second_colour <= b;
    do @(posedge clk); while (!in_ready);
    pending_shades.push_back(typed ? want : predict_shade(a, b));
  endtask

  task automatic pause_sender();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic colour_t random_colour();
    byte unsigned edge_codes [8] = '{0, 1, 10, 11, 12, 128, 254, 255};
    colour_t c;
    case ($urandom_range(0, 7))
      0: c = {edge_codes[$urandom_range(0, 7)], edge_codes[$urandom_range(0, 7)],
              edge_codes[$urandom_range(0, 7)]};
      1: c = {3{8'($urandom_range(0, 255))}};
      2: c = {8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
              8'($urandom_range(0, 12))};
      default: c = 24'($urandom);
    endcase
    return c;
  endfunction

  task automatic send_random(int n);
    int burst;
    colour_t a;
    shade_t none;
    none = '{default: '0};
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        pause_sender();
        burst = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      a = random_colour();
      send_item(a, $urandom_range(0, 9) == 0 ? a : random_colour(), 1'b0, none);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  // Waits for every pending result, then lets the pipeline settle.
  task automatic drain();
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GROUND_COLOUR) ground_mirror = value[COLOUR_W-1:0];
    else thresh_mirror = value[THRESH_W-1:0];
  endtask

  // Directed rows: typed expectations for black and white corners under the
  // reset configuration (ground black, threshold 3.0), predictor for the rest.
  localparam logic [RATIO_W-1:0] RATIO_ONE = 1 << FB;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 21 << FB;
  localparam logic [LUM_W-1:0]   LUM_FULL  = 1 << FB;
  stim_row_t directed [15];

  initial begin
    shade_t none;
    none = '{default: '0};
    directed[0]  = '{24'h000000, 24'hFFFFFF, 1, '{0, LUM_FULL, RATIO_MAX, 24'h000000}};
    directed[1]  = '{24'hFFFFFF, 24'h000000, 1, '{LUM_FULL, 0, RATIO_MAX, COLOUR_WHITE}};
    directed[2]  = '{24'h000000, 24'h000000, 1, '{0, 0, RATIO_ONE, COLOUR_WHITE}};
    directed[3]  = '{24'hFFFFFF, 24'hFFFFFF, 1, '{LUM_FULL, LUM_FULL, RATIO_ONE, 24'h000000}};
    directed[4]  = '{24'h0A0A0A, 24'h0B0B0B, 0, none};
    directed[5]  = '{24'h010101, 24'hFEFEFE, 0, none};
    directed[6]  = '{24'hFF0000, 24'h00FF00, 0, none};
    directed[7]  = '{24'h0000FF, 24'hFF00FF, 0, none};
    directed[8]  = '{24'h808080, 24'h808080, 0, none};
    directed[9]  = '{24'h767676, 24'h000000, 0, none};
    directed[10] = '{24'h000000, 24'h777777, 0, none};
    directed[11] = '{24'h0C0B0A, 24'hF5AA55, 0, none};
    directed[12] = '{24'hAAAAAA, 24'h555555, 0, none};
    directed[13] = '{24'h00000A, 24'h0B0000, 0, none};
    directed[14] = '{24'h123456, 24'hFEDCBA, 0, none};

    for (int c = 0; c < 256; c++) lin_table[c] = linearise(c);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_first_colour = '0;
    in_second_colour = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stall_mode = 0;
    stall_cnt = 0;
    mismatches = 0;
    cycles = 0;
    ground_mirror = '0;
    thresh_mirror = THRESH_W'(THRESH_RESET);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_item(directed[i].first, directed[i].second, directed[i].typed, directed[i].want);
      if (i % 4 == 3) pause_sender();
    end
    in_valid <= 1'b0;
    send_random(300);
    drain();

    // Threshold at 1.0: white ink is always chosen.
    write_reg(REG_GROUND_COLOUR, 24'($urandom));
    write_reg(REG_INK_THRESHOLD, 24'd65536);
    send_random(250);
    drain();

    // Threshold at 21.0 with junk above bit 20, ground fully white.
    write_reg(REG_GROUND_COLOUR, COLOUR_WHITE);
    write_reg(REG_INK_THRESHOLD, 24'hE00000 | 24'd1376256);
    send_random(250);
    drain();

    // Above the top of the range: ground colour always wins.
    write_reg(REG_GROUND_COLOUR, 24'h5A3C96);
    write_reg(REG_INK_THRESHOLD, 24'h1FFFFF);
    send_random(200);
    drain();

    // Below 1.0: white always wins.
    write_reg(REG_INK_THRESHOLD, 24'h000000);
    send_random(150);
    drain();

    write_reg(REG_GROUND_COLOUR, 24'($urandom));
    write_reg(REG_INK_THRESHOLD, 24'($urandom_range(65536, 1376256)));
    send_random(250);
    drain();

    if (mismatches == 0 && pending_shades.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
